>>> sv/cfpa_pkg.sv
`timescale 1ns / 1ps

package cfpa_pkg;

    // Default table size and fixed field widths
    localparam int FRAME_COUNT_DEF = 256;
    localparam int LEN_W           = 21;
    localparam int ADDR_W          = 20;
    localparam int PID_W           = 8;
    localparam int ST_W            = 2;
    localparam int PAGES_W         = 10;
    localparam int PAGE_SHIFT      = 12;
    localparam logic [PAGE_SHIFT-1:0] PAGE_ROUND = 12'd4095;

    // Request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_OWNER = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_ARG   = 2'd3;

    typedef struct packed {
        logic              opcode;
        logic [LEN_W-1:0]  length_bytes;
        logic [PID_W-1:0]  process_id;
        logic [ADDR_W-1:0] address;
        logic [PID_W-1:0]  requester_owner;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] block_address;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic            load;
        logic            clear;
        logic            scan;
        logic            mark;
        logic            fissue;
        logic            rel;
        logic            res_load;
        logic [ST_W-1:0] res_status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_zero;
        logic frame_oob;
        logic op_free;
        logic clr_last;
        logic scan_hit;
        logic scan_miss;
        logic mark_last;
        logic owner_ok;
        logic rel_done;
    } t_dp_stat;

endpackage

>>> sv/contiguous_page_frame_allocator.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in_item  (cfpa_pkg::t_in_item)
// out       output     o_out_valid / i_out_ready  o_out_item (cfpa_pkg::t_out_item)
//
// One item at a time; each item gives exactly one result item.
// Allocate scans the table for a free run and then marks its pages; free checks
// the owner of the named frame and then releases the frames whose block starts there.
// Both walk the frame table through its single read and single write port.
// After reset a clearing pass empties the table; no item is accepted during it.
// A stalled result waits in the output register while the next item is accepted
// and worked on.

module contiguous_page_frame_allocator #(
    parameter int FRAME_COUNT = cfpa_pkg::FRAME_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cfpa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cfpa_pkg::t_out_item o_out_item
);

    cfpa_pkg::t_dp_cmd  dp_cmd;
    cfpa_pkg::t_dp_stat dp_stat;

    cfpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    cfpa_dp #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .i_item   (i_in_item),
        .o_stat   (dp_stat),
        .o_result (o_out_item)
    );

    // A failed request never carries an address
    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != cfpa_pkg::ST_OK) |->
        (o_out_item.block_address == '0))
        else $error("failed result carries a nonzero address");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted item");

    // A new result comes only out of a busy cycle
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without work in progress");

endmodule

>>> sv/cfpa_dp.sv
`timescale 1ns / 1ps

module cfpa_dp #(
    parameter int FRAME_COUNT = cfpa_pkg::FRAME_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfpa_pkg::t_dp_cmd   i_cmd,
    input  cfpa_pkg::t_in_item  i_item,
    output cfpa_pkg::t_dp_stat  o_stat,
    output cfpa_pkg::t_out_item o_result
);

    localparam int FW = $clog2(FRAME_COUNT);
    localparam int PW = $clog2(FRAME_COUNT + 1);
    localparam int CW = ((PW > cfpa_pkg::PAGES_W) ? PW : cfpa_pkg::PAGES_W) + 1;
    localparam int SW = cfpa_pkg::LEN_W + 1;

    typedef struct packed {
        logic                       used;
        logic [cfpa_pkg::PID_W-1:0] owner;
        logic [FW-1:0]              start;
    } t_entry;

    t_entry mem [FRAME_COUNT];

    cfpa_pkg::t_in_item            r_req;
    logic [cfpa_pkg::PAGES_W-1:0]  r_pages;
    logic [cfpa_pkg::PAGES_W-1:0]  r_cnt;
    logic [FW-1:0]                 r_frame;
    logic [FW-1:0]                 r_start;
    logic [FW-1:0]                 r_rd_idx;
    logic [PW-1:0]                 r_ptr;
    logic [PW-1:0]                 r_run;
    logic                          r_rd_vld;
    t_entry                        r_rd;
    cfpa_pkg::t_out_item           r_result;

    logic [SW-1:0]                 len_sum;
    logic [cfpa_pkg::PAGES_W-1:0]  in_pages;
    logic [PW-1:0]                 run_inc;
    logic                          ptr_end;
    logic                          hit;
    logic [FW-1:0]                 hit_start;
    logic                          rel_match;
    logic                          rd_en;
    logic                          wr_en;
    logic [FW-1:0]                 wr_addr;
    logic [FW-1:0]                 rd_addr;
    t_entry                        wr_data;
    logic [31:0]                   start_bytes;

    // Round the request length up to whole pages
    assign len_sum  = SW'(i_item.length_bytes) + SW'(cfpa_pkg::PAGE_ROUND);
    assign in_pages = len_sum[SW-1:cfpa_pkg::PAGE_SHIFT];

    // Scan and release bookkeeping
    assign run_inc   = r_run + PW'(1);
    assign ptr_end   = (r_ptr == PW'(FRAME_COUNT));
    assign hit       = r_rd_vld && !r_rd.used && (CW'(run_inc) >= CW'(r_pages));
    assign hit_start = (r_run == '0) ? r_rd_idx : r_start;
    assign rel_match = r_rd.used && (r_rd.start == r_frame);

    // Status toward the controller
    always_comb begin
        o_stat.len_zero  = (r_req.length_bytes == '0);
        o_stat.frame_oob = (32'(r_req.address >> cfpa_pkg::PAGE_SHIFT) >= 32'(FRAME_COUNT));
        o_stat.op_free   = (r_req.opcode == cfpa_pkg::OP_FREE);
        o_stat.clr_last  = (r_ptr == PW'(FRAME_COUNT - 1));
        o_stat.scan_hit  = hit;
        o_stat.scan_miss = !r_rd_vld && ptr_end;
        o_stat.mark_last = (r_cnt == cfpa_pkg::PAGES_W'(1));
        o_stat.owner_ok  = r_rd.used && (r_rd.owner == r_req.requester_owner);
        o_stat.rel_done  = (r_rd_vld && !rel_match) || (!r_rd_vld && ptr_end);
    end

    // Select table read and write for the current command
    always_comb begin
        rd_en   = ((i_cmd.scan || i_cmd.rel) && !ptr_end) || i_cmd.fissue;
        rd_addr = r_ptr[FW-1:0];
        wr_en   = 1'b0;
        wr_addr = r_ptr[FW-1:0];
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.mark) begin
            wr_en         = 1'b1;
            wr_data.used  = 1'b1;
            wr_data.owner = r_req.process_id;
            wr_data.start = r_start;
        end else if (i_cmd.rel && r_rd_vld && rel_match) begin
            wr_en         = 1'b1;
            wr_addr       = r_rd_idx;
            wr_data.used  = 1'b0;
            wr_data.owner = r_rd.owner;
            wr_data.start = r_rd.start;
        end
    end

    // Frame table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    // Walk pointer, read tracking and run search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_req    <= i_item;
            r_pages  <= in_pages;
            r_frame  <= FW'(i_item.address >> cfpa_pkg::PAGE_SHIFT);
            r_ptr    <= (i_item.opcode == cfpa_pkg::OP_FREE) ?
                        PW'(i_item.address >> cfpa_pkg::PAGE_SHIFT) : '0;
            r_run    <= '0;
            r_rd_vld <= 1'b0;
        end else if (i_cmd.clear || i_cmd.mark) begin
            r_ptr <= r_ptr + PW'(1);
            if (i_cmd.mark) begin
                r_cnt <= r_cnt - cfpa_pkg::PAGES_W'(1);
            end
        end else if (i_cmd.fissue) begin
            r_ptr    <= r_ptr + PW'(1);
            r_rd_vld <= 1'b1;
            r_rd_idx <= r_ptr[FW-1:0];
        end else if (i_cmd.scan && hit) begin
            // Found a run: rewind to its start for marking
            r_start <= hit_start;
            r_ptr   <= PW'(hit_start);
            r_cnt   <= r_pages;
        end else if (i_cmd.scan || i_cmd.rel) begin
            if (!ptr_end) begin
                r_ptr <= r_ptr + PW'(1);
            end
            r_rd_vld <= !ptr_end;
            r_rd_idx <= r_ptr[FW-1:0];
            if (i_cmd.scan && r_rd_vld) begin
                if (r_rd.used) begin
                    r_run <= '0;
                end else begin
                    r_run <= run_inc;
                    if (r_run == '0) begin
                        r_start <= r_rd_idx;
                    end
                end
            end
        end
    end

    // Result register
    assign start_bytes = 32'(r_start) << cfpa_pkg::PAGE_SHIFT;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_result.status <= i_cmd.res_status;
            r_result.block_address <=
                (i_cmd.res_status == cfpa_pkg::ST_OK && r_req.opcode == cfpa_pkg::OP_ALLOC) ?
                start_bytes[cfpa_pkg::ADDR_W-1:0] : '0;
        end
    end

    assign o_result = r_result;

endmodule

>>> sv/cfpa_ctrl.sv
`timescale 1ns / 1ps

module cfpa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  cfpa_pkg::t_dp_stat i_stat,
    output cfpa_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_MARK   = 4'd4;
    localparam logic [3:0] S_FISSUE = 4'd5;
    localparam logic [3:0] S_FCHK   = 4'd6;
    localparam logic [3:0] S_FREL   = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [cfpa_pkg::ST_W-1:0] r_code;
    logic [cfpa_pkg::ST_W-1:0] n_code;
    logic                     r_out_vld;
    logic                     n_out_vld;

    // Sequence one item through decode, search or release, then result
    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op_free) begin
                    if (i_stat.frame_oob) begin
                        n_code  = cfpa_pkg::ST_BAD_ARG;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_FISSUE;
                    end
                end else if (i_stat.len_zero) begin
                    n_code  = cfpa_pkg::ST_BAD_ARG;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_hit) begin
                    n_state = S_MARK;
                end else if (i_stat.scan_miss) begin
                    n_code  = cfpa_pkg::ST_NO_SPACE;
                    n_state = S_DONE;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_stat.mark_last) begin
                    n_code  = cfpa_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_FISSUE: begin
                o_cmd.fissue = 1'b1;
                n_state      = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.owner_ok) begin
                    n_state = S_FREL;
                end else begin
                    n_code  = cfpa_pkg::ST_NOT_OWNER;
                    n_state = S_DONE;
                end
            end
            S_FREL: begin
                o_cmd.rel = 1'b1;
                if (i_stat.rel_done) begin
                    n_code  = cfpa_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = r_code;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    assign n_out_vld = o_cmd.res_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_code    <= cfpa_pkg::ST_OK;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_code    <= n_code;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

>>> tb/tb_contiguous_page_frame_allocator.sv
`timescale 1ns / 1ps

module tb_contiguous_page_frame_allocator;
    import cfpa_pkg::*;

    localparam int FRAMES      = FRAME_COUNT_DEF;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    localparam int MAX_LEN     = 1048576;
    localparam int PHASE_ITEMS = 380;
    localparam int HOLD_CYCLES = 700;
    localparam int SETTLE      = 600;

    // Track the frame table and the answers it must produce
    class page_frame_board;
        bit          frame_used [FRAMES];
        logic [7:0]  frame_pid  [FRAMES];
        int unsigned frame_head [FRAMES];
        t_out_item   expected_answers [$];
        int          failures;
        int          requests;
        int          answers;
        int          status_seen [4];

        function new();
            foreach (frame_used[i]) frame_used[i] = 1'b0;
            failures = 0;
            requests = 0;
            answers  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        // Apply one accepted request to the table and queue its answer
        function void note_request(t_in_item req);
            t_out_item   ans;
            int unsigned pages, run, first, i, frame;
            bit          found;
            bit          walking;
            ans.status        = ST_OK;
            ans.block_address = '0;
            requests++;
            if (req.opcode == OP_ALLOC) begin
                if (req.length_bytes == '0) begin
                    ans.status = ST_BAD_ARG;
                end else begin
                    pages = (32'(req.length_bytes) + 32'(PAGE_ROUND)) >> PAGE_SHIFT;
                    run   = 0;
                    first = 0;
                    found = 1'b0;
                    for (i = 0; i < FRAMES && !found; i++) begin
                        if (frame_used[i]) begin
                            run = 0;
                        end else begin
                            if (run == 0) first = i;
                            run++;
                            if (run >= pages) found = 1'b1;
                        end
                    end
                    if (!found) begin
                        ans.status = ST_NO_SPACE;
                    end else begin
                        for (i = first; i < first + pages; i++) begin
                            frame_used[i] = 1'b1;
                            frame_pid[i]  = req.process_id;
                            frame_head[i] = first;
                        end
                        ans.block_address = ADDR_W'(first << PAGE_SHIFT);
                    end
                end
            end else begin
                frame = 32'(req.address) >> PAGE_SHIFT;
                if (frame >= FRAMES) begin
                    ans.status = ST_BAD_ARG;
                end else if (!frame_used[frame] || frame_pid[frame] != req.requester_owner) begin
                    ans.status = ST_NOT_OWNER;
                end else begin
                    // Release upward while frames still belong to this block
                    i       = frame;
                    walking = 1'b1;
                    while (walking && i < FRAMES) begin
                        if (!frame_used[i] || frame_head[i] != frame) begin
                            walking = 1'b0;
                        end else begin
                            frame_used[i] = 1'b0;
                            i++;
                        end
                    end
                end
            end
            expected_answers.push_back(ans);
        endfunction

        // Compare one result item with the oldest answer waiting
        function void check_answer(t_out_item got);
            t_out_item want;
            answers++;
            if (expected_answers.size() == 0) begin
                $error("result item with no request outstanding: status %0d, block_address %h",
                       got.status, got.block_address);
                failures++;
                return;
            end
            want = expected_answers.pop_front();
            status_seen[want.status]++;
            if (got.status !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.block_address !== want.block_address) begin
                $error("block_address: expected %h, actual %h",
                       want.block_address, got.block_address);
                failures++;
            end
        endfunction

        // Pick a random frame in use; block heads only unless any_frame
        function bit pick_block(bit any_frame, output int unsigned frame,
                                output logic [7:0] owner);
            int unsigned origin, k, f;
            bit          found;
            origin = $urandom_range(0, FRAMES - 1);
            found  = 1'b0;
            frame  = 0;
            owner  = '0;
            for (k = 0; k < FRAMES && !found; k++) begin
                f = (origin + k) % FRAMES;
                if (frame_used[f] && (any_frame || frame_head[f] == f)) begin
                    found = 1'b1;
                    frame = f;
                    owner = frame_pid[f];
                end
            end
            return found;
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;

    page_frame_board board;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              hold_requests;

    contiguous_page_frame_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_in_item make_alloc(int unsigned len, logic [7:0] pid);
        t_in_item req;
        req.opcode          = OP_ALLOC;
        req.length_bytes    = LEN_W'(len);
        req.process_id      = pid;
        req.address         = ADDR_W'($urandom);
        req.requester_owner = PID_W'($urandom);
        return req;
    endfunction

    function automatic t_in_item make_free(int unsigned addr, logic [7:0] owner);
        t_in_item req;
        req.opcode          = OP_FREE;
        req.length_bytes    = LEN_W'($urandom_range(0, MAX_LEN));
        req.process_id      = PID_W'($urandom);
        req.address         = ADDR_W'(addr);
        req.requester_owner = owner;
        return req;
    endfunction

    // Mostly well-formed allocate/free traffic, with some noise
    function automatic t_in_item make_random_item();
        int unsigned r, s, len, frame;
        logic [7:0]  owner;
        r = $urandom_range(0, 99);
        s = $urandom_range(0, 99);
        if (r >= 45 && r < 85 && board.pick_block(1'b0, frame, owner)) begin
            return make_free(frame * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1), owner);
        end
        if (r >= 85) begin
            if (s < 40 || !board.pick_block(s >= 70, frame, owner)) begin
                return make_free($urandom_range(0, 20'hFFFFF), PID_W'($urandom));
            end
            if (s < 70) begin
                owner = owner ^ PID_W'($urandom_range(1, 255));
            end
            return make_free(frame * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1), owner);
        end
        if (s < 85) len = $urandom_range(1, 8 * PAGE_BYTES);
        else if (s < 95) len = $urandom_range(1, 64 * PAGE_BYTES);
        else if (s < 98) len = $urandom_range(0, MAX_LEN);
        else len = 0;
        return make_alloc(len, PID_W'($urandom));
    endfunction

    // Offer one item, idling at random first, and hold it until accepted
    task automatic send_item(input t_in_item req);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_item  = req;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        board.note_request(req);
    endtask

    // Stop offering and wait until every answer is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_random(input int count, input int hold_at);
        int n;
        for (n = 0; n < count; n++) begin
            if (n == hold_at) hold_requests++;
            send_item(make_random_item());
        end
    endtask

    // Drive result ready; a hold request stalls it for a long stretch
    initial begin
        int hold_served;
        hold_served = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_served++;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Check every accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_answer(o_out_item);
    end

    initial begin
        board         = new();
        hold_requests = 0;
        send_idle_pct = 24;
        recv_idle_pct = 59;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_item     = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: field extremes, partial frees, full table, short tail run
        send_item(make_alloc(0, 8'h01));
        send_item(make_alloc(1, 8'hFF));
        send_item(make_alloc(PAGE_BYTES, 8'h00));
        send_item(make_alloc(PAGE_BYTES + 1, 8'hAA));
        send_item(make_alloc(MAX_LEN, 8'h55));
        send_item(make_free(0, 8'h00));
        send_item(make_free(20'h00FFF, 8'hFF));
        send_item(make_free(3 * PAGE_BYTES, 8'hAA));
        send_item(make_free(0, 8'hFF));
        send_item(make_free(20'hFFFFF, 8'h00));
        send_item(make_free(2 * PAGE_BYTES + 20'h7FF, 8'hAA));
        send_item(make_free(PAGE_BYTES, 8'h00));
        send_item(make_alloc(MAX_LEN, 8'h3C));
        send_item(make_alloc(1, 8'h00));
        send_item(make_free(0, 8'h3C));
        send_item(make_alloc(250 * PAGE_BYTES, 8'h07));
        send_item(make_alloc(7 * PAGE_BYTES, 8'h08));
        send_item(make_alloc(6 * PAGE_BYTES - 1, 8'h09));
        send_item(make_free(250 * PAGE_BYTES, 8'h09));
        send_item(make_free(0, 8'h07));
        send_item(make_alloc(MAX_LEN - 1, 8'h12));
        send_item(make_free(0, 8'h12));
        drain();

        // Random traffic over three idle patterns
        send_random(PHASE_ITEMS, PHASE_ITEMS / 2);
        drain();
        send_idle_pct = 59;
        recv_idle_pct = 24;
        send_random(PHASE_ITEMS, -1);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random(PHASE_ITEMS, 10);
        drain();
        repeat (SETTLE) @(posedge i_clk);

        $display("Ran %0d requests and checked %0d results under three idle patterns",
                 board.requests, board.answers);
        $display("Status mix: %0d ok, %0d no space, %0d not owner, %0d bad argument",
                 board.status_seen[ST_OK], board.status_seen[ST_NO_SPACE],
                 board.status_seen[ST_NOT_OWNER], board.status_seen[ST_BAD_ARG]);
        if (board.failures == 0 && board.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
